@@ src/s9wp_pkg.sv @@
// package for the simple9 word packer
// layout tables, value classification and the controller/datapath interface structs
// no dependencies
package s9wp_pkg;

  localparam int SLOTS       = 28;
  localparam int DATA_W      = 32;
  localparam int SEL_W       = 4;
  localparam int PAY_W       = 28;
  localparam int CNT_W       = 5;
  localparam int PTR_W       = $clog2(SLOTS);
  localparam int NUM_LAYOUTS = 9;

  localparam logic [SEL_W-1:0] CLS_TOO_WIDE = 4'd9;

  typedef logic [SEL_W-1:0] cls_t;

  typedef struct packed {
    logic accept;
    logic decide;
    logic pack;
    logic load;
    logic err_emit;
  } cmd_t;

  typedef struct packed {
    logic trigger;
    logic found;
    logic rem_last;
    logic drain_more;
    logic out_free;
  } status_t;

  function automatic logic [CNT_W-1:0] layout_count(input logic [SEL_W-1:0] sel);
    logic [CNT_W-1:0] c;
    case (sel)
      4'd0:    c = 5'd28;
      4'd1:    c = 5'd14;
      4'd2:    c = 5'd9;
      4'd3:    c = 5'd7;
      4'd4:    c = 5'd5;
      4'd5:    c = 5'd4;
      4'd6:    c = 5'd3;
      4'd7:    c = 5'd2;
      default: c = 5'd1;
    endcase
    return c;
  endfunction

  function automatic logic [CNT_W-1:0] layout_bits(input logic [SEL_W-1:0] sel);
    logic [CNT_W-1:0] b;
    case (sel)
      4'd0:    b = 5'd1;
      4'd1:    b = 5'd2;
      4'd2:    b = 5'd3;
      4'd3:    b = 5'd4;
      4'd4:    b = 5'd5;
      4'd5:    b = 5'd7;
      4'd6:    b = 5'd9;
      4'd7:    b = 5'd14;
      default: b = 5'd28;
    endcase
    return b;
  endfunction

  // smallest layout whose slot width holds the value
  function automatic cls_t value_class(input logic [DATA_W-1:0] v);
    cls_t c;
    if (v[31:28] != '0)      c = CLS_TOO_WIDE;
    else if (v[27:14] != '0) c = 4'd8;
    else if (v[13:9] != '0)  c = 4'd7;
    else if (v[8:7] != '0)   c = 4'd6;
    else if (v[6:5] != '0)   c = 4'd5;
    else if (v[4])           c = 4'd4;
    else if (v[3])           c = 4'd3;
    else if (v[2])           c = 4'd2;
    else if (v[1])           c = 4'd1;
    else                     c = 4'd0;
    return c;
  endfunction

endpackage

@@ src/s9wp_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module s9wp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 28
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/s9wp_ctrl.sv @@
// controller state machine for the simple9 word packer
// depends on s9wp_pkg (cmd_t, status_t)
module s9wp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  s9wp_pkg::status_t st,
  output s9wp_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DECIDE = 3'b010,
    ST_PACK   = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (st.trigger) state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (st.found) begin
          cmd.decide = 1'b1;
          state_nxt  = ST_PACK;
        end else if (st.out_free) begin
          cmd.err_emit = 1'b1;
          state_nxt    = st.drain_more ? ST_DECIDE : ST_IDLE;
        end
      end
      ST_PACK: begin
        if (!st.rem_last) begin
          cmd.pack = 1'b1;
        end else if (st.out_free) begin
          cmd.pack  = 1'b1;
          cmd.load  = 1'b1;
          state_nxt = st.drain_more ? ST_DECIDE : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/s9wp_dp.sv @@
// datapath for the simple9 word packer: value ring buffer, class shift line,
// layout choice, word accumulator and output register
// depends on s9wp_pkg and s9wp_ram
module s9wp_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  s9wp_pkg::cmd_t                cmd,
  output s9wp_pkg::status_t             st,
  input  logic [s9wp_pkg::DATA_W-1:0]   in_value,
  input  logic                          in_eoa,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [s9wp_pkg::DATA_W-1:0]   out_word,
  output logic                          out_err,
  output logic                          out_last
);

  localparam int SLOTS = s9wp_pkg::SLOTS;
  localparam int PTR_W = s9wp_pkg::PTR_W;
  localparam int CNT_W = s9wp_pkg::CNT_W;
  localparam int SEL_W = s9wp_pkg::SEL_W;
  localparam int PAY_W = s9wp_pkg::PAY_W;
  localparam int NL    = s9wp_pkg::NUM_LAYOUTS;

  logic [PTR_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             eoa_r;
  s9wp_pkg::cls_t   class_r [SLOTS];
  s9wp_pkg::cls_t   class_nxt [SLOTS];

  logic [SEL_W-1:0] sel_r, sel_pick;
  logic [CNT_W-1:0] rem_r, n_pick, bits_cur, used_r, used_nxt;
  logic [PAY_W-1:0] acc_r, acc_nxt, mask_cur, pay_final;
  logic [NL-1:0]    ok;
  logic             found;
  logic [s9wp_pkg::DATA_W-1:0] rd_data;

  logic                         out_valid_r;
  logic [s9wp_pkg::DATA_W-1:0]  out_word_r;
  logic                         out_err_r, out_last_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(SLOTS - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  s9wp_ram #(
    .WIDTH(s9wp_pkg::DATA_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.accept),
    .waddr(tail_r),
    .wdata(in_value),
    .raddr(head_nxt),
    .rdata(rd_data)
  );

  // layout choice from the classes of the pending head
  always_comb begin
    for (int s = 0; s < NL; s++) begin
      ok[s] = 1'b1;
      for (int i = 0; i < SLOTS; i++) begin
        if (CNT_W'(i) < s9wp_pkg::layout_count(SEL_W'(s)) && CNT_W'(i) < count_r &&
            class_r[i] > SEL_W'(s)) begin
          ok[s] = 1'b0;
        end
      end
    end
    found    = 1'b0;
    sel_pick = '0;
    for (int s = NL - 1; s >= 0; s--) begin
      if (ok[s]) begin
        found    = 1'b1;
        sel_pick = SEL_W'(s);
      end
    end
    n_pick = (count_r < s9wp_pkg::layout_count(sel_pick)) ?
             count_r : s9wp_pkg::layout_count(sel_pick);
  end

  always_comb begin
    bits_cur  = s9wp_pkg::layout_bits(sel_r);
    mask_cur  = (PAY_W'(1) << bits_cur) - PAY_W'(1);
    acc_nxt   = (acc_r << bits_cur) | (rd_data[PAY_W-1:0] & mask_cur);
    used_nxt  = used_r + bits_cur;
    pay_final = acc_nxt << (CNT_W'(PAY_W) - used_nxt);
  end

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    for (int i = 0; i < SLOTS; i++) begin
      class_nxt[i] = class_r[i];
    end
    if (cmd.accept) begin
      tail_nxt  = ptr_inc(tail_r);
      count_nxt = count_r + CNT_W'(1);
      for (int i = 0; i < SLOTS; i++) begin
        if (count_r == CNT_W'(i)) class_nxt[i] = s9wp_pkg::value_class(in_value);
      end
    end
    if (cmd.pack || cmd.err_emit) begin
      head_nxt  = ptr_inc(head_r);
      count_nxt = count_r - CNT_W'(1);
      for (int i = 0; i < SLOTS - 1; i++) begin
        class_nxt[i] = class_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      if (cmd.load || cmd.err_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOTS; i++) begin
      class_r[i] <= class_nxt[i];
    end
    if (cmd.accept) eoa_r <= in_eoa;
    if (cmd.decide) begin
      sel_r  <= sel_pick;
      rem_r  <= n_pick;
      acc_r  <= '0;
      used_r <= '0;
    end else if (cmd.pack) begin
      rem_r  <= rem_r - CNT_W'(1);
      acc_r  <= acc_nxt;
      used_r <= used_nxt;
    end
    if (cmd.load) begin
      out_word_r <= {sel_r, pay_final};
      out_err_r  <= 1'b0;
      out_last_r <= eoa_r && (count_r == CNT_W'(1));
    end else if (cmd.err_emit) begin
      out_word_r <= '0;
      out_err_r  <= 1'b1;
      out_last_r <= eoa_r && (count_r == CNT_W'(1));
    end
  end

  assign st.trigger    = in_eoa || (count_r == CNT_W'(SLOTS - 1));
  assign st.found      = found;
  assign st.rem_last   = (rem_r == CNT_W'(1));
  assign st.drain_more = eoa_r && (count_r != CNT_W'(1));
  assign st.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_err   = out_err_r;
  assign out_last  = out_last_r;

endmodule

@@ src/simple9_word_packer_top.sv @@
// top level of the simple9 word packer
// depends on s9wp_pkg, s9wp_ctrl, s9wp_dp (which holds s9wp_ram)
//
//   channel | direction | tdata                  | tuser           | tlast
//   in_     | input     | [31:0] value           | -               | end of array
//   out_    | output    | [31:0] packed word     | [0] range error | last word of array
//
// a value is taken while idle, when no word falls due; a word costs a layout decision
// and one pack step, a ram read, per value it carries; an error word needs no pack step
// after the end mark the pending values drain in as many words as needed, no input taken
// reset empties the buffer at once: no clearing pass
// one finished word waits in the output register; the block stalls only when the next
// word is ready while that one has not been taken
module simple9_word_packer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] packed_word
  output logic [0:0]  out_tuser,  // [0] range_error
  output logic        out_tlast
);

  s9wp_pkg::cmd_t    cmd;
  s9wp_pkg::status_t st;
  logic              out_err;

  s9wp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  s9wp_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .st       (st),
    .in_value (in_tdata),
    .in_eoa   (in_tlast),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_word (out_tdata),
    .out_err  (out_err),
    .out_last (out_tlast)
  );

  assign out_tuser[0] = out_err;

endmodule

@@ src/s9wp_checker.sv @@
// port-level checks for the simple9 word packer, bound to the top level
// depends on simple9_word_packer_top
module s9wp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // a stalled request holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output request changed while stalled");

  // error words are all zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 32'd0)
    else $error("error word not zero");

  // selectors stay within the nine layouts
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[31:28] <= 4'd8)
    else $error("selector out of range");

  // an end mark always starts a drain, so input closes
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input still open after end of array");

endmodule

bind simple9_word_packer_top s9wp_checker u_s9wp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tlast  (in_tlast),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
